// File: rtl/core/dlwc_pkg.sv
// ----------------------------------------------------------------------------
// dlwc_pkg
// Shared types and constants for the door lock window closer.
// ----------------------------------------------------------------------------
package dlwc_pkg;

	typedef enum logic [1:0] {
		MODE_UNLOCKED_OPEN   = 2'd0,
		MODE_UNLOCKED_CLOSED = 2'd1,
		MODE_LOCKED_CLOSED   = 2'd2,
		MODE_CLOSING         = 2'd3
	} mode_t;

	localparam int DELAY_W = 16;
	localparam int MULT_W  = 8;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'hFFFF;
	localparam logic [MULT_W-1:0]  MULT_RESET  = 8'd2;

	// register index taken from the word address
	localparam logic REG_WINDOW_DELAY      = 1'b0;
	localparam logic REG_WINDOW_MULTIPLIER = 1'b1;

	typedef struct packed {
		logic [DELAY_W-1:0] window_delay;
		logic [MULT_W-1:0]  window_multiplier;
	} cfg_t;

endpackage

// File: rtl/core/dlwc_regs.sv
// ----------------------------------------------------------------------------
// dlwc_regs
// APB register file holding the window delay and multiplier.
// ----------------------------------------------------------------------------
module dlwc_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output dlwc_pkg::cfg_t     cfg
);
	import dlwc_pkg::*;

	logic [DELAY_W-1:0] delay_q;
	logic [MULT_W-1:0]  mult_q;
	logic               wr_en;
	logic               reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	// low address bits are the byte offset within a register
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			mult_q  <= MULT_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_WINDOW_DELAY:      delay_q <= pwdata[DELAY_W-1:0];
				REG_WINDOW_MULTIPLIER: mult_q  <= pwdata[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (reg_sel)
			REG_WINDOW_DELAY:      prdata = {{(32-DELAY_W){1'b0}}, delay_q};
			REG_WINDOW_MULTIPLIER: prdata = {{(32-MULT_W){1'b0}}, mult_q};
			default:               prdata = 32'd0;
		endcase
	end

	assign cfg.window_delay      = delay_q;
	assign cfg.window_multiplier = mult_q;

endmodule

// File: rtl/core/dlwc_fsm.sv
// ----------------------------------------------------------------------------
// dlwc_fsm
// Mode state machine with the two-level window closing countdown.
// ----------------------------------------------------------------------------
module dlwc_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             door_open,
	input  logic             vehicle_locked,
	input  dlwc_pkg::cfg_t   cfg,
	output dlwc_pkg::mode_t  mode_next,
	output dlwc_pkg::mode_t  mode_cur
);
	import dlwc_pkg::*;

	mode_t              mode_q, mode_d;
	logic [DELAY_W-1:0] tick_q, tick_d;
	logic [MULT_W-1:0]  reload_q, reload_d;
	mode_t              door_mode;

	assign door_mode = door_open ? MODE_UNLOCKED_OPEN : MODE_UNLOCKED_CLOSED;

	always_comb begin
		mode_d   = mode_q;
		tick_d   = tick_q;
		reload_d = reload_q;
		unique case (mode_q)
			MODE_UNLOCKED_OPEN: begin
				if (!door_open && !vehicle_locked)
					mode_d = MODE_UNLOCKED_CLOSED;
			end
			MODE_UNLOCKED_CLOSED: begin
				if (door_open) begin
					mode_d = MODE_UNLOCKED_OPEN;
				end else if (vehicle_locked) begin
					tick_d   = cfg.window_delay;
					reload_d = cfg.window_multiplier;
					mode_d   = MODE_CLOSING;
				end
			end
			MODE_CLOSING: begin
				if (tick_q != '0) begin
					tick_d = tick_q - 1'b1;
				end else if (reload_q != '0) begin
					tick_d   = cfg.window_delay;
					reload_d = reload_q - 1'b1;
				end else begin
					mode_d = MODE_LOCKED_CLOSED;
				end
				// abort overrides the countdown
				if (door_open || !vehicle_locked)
					mode_d = door_mode;
			end
			MODE_LOCKED_CLOSED: begin
				if (!vehicle_locked)
					mode_d = door_mode;
			end
			default: mode_d = MODE_UNLOCKED_OPEN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_UNLOCKED_OPEN;
			tick_q   <= DELAY_RESET;
			reload_q <= MULT_RESET;
		end else if (step) begin
			mode_q   <= mode_d;
			tick_q   <= tick_d;
			reload_q <= reload_d;
		end
	end

	assign mode_next = mode_d;
	assign mode_cur  = mode_q;

endmodule

// File: rtl/core/dlwc_out.sv
// ----------------------------------------------------------------------------
// dlwc_out
// Result register: decodes the mode into the output lines and holds the beat.
// ----------------------------------------------------------------------------
module dlwc_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  dlwc_pkg::mode_t  mode,
	output logic             space,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata
);
	import dlwc_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	logic [7:0] data_d;
	logic       closing;

	assign closing = (mode == MODE_CLOSING);

	always_comb begin
		data_d[1:0] = mode;
		data_d[2]   = (mode != MODE_UNLOCKED_CLOSED);
		data_d[3]   = closing;
		data_d[4]   = closing;
		data_d[5]   = (mode != MODE_UNLOCKED_OPEN);
		data_d[6]   = !closing;
		data_d[7]   = !closing;
	end

	assign space = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= data_d;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

endmodule

// File: rtl/core/door_lock_window_closer.sv
// ----------------------------------------------------------------------------
// door_lock_window_closer
// Door and lock polling controller that runs the window closers on locking.
// A beat passes from the input register to the result register. Throughput:
// one beat per cycle while the output is not stalled; the mode update and the
// countdown decrement sit in one stage between the two registers.
// Reset: mode unlocked open, countdown at its reset values, both stages empty.
// ----------------------------------------------------------------------------
module door_lock_window_closer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] door_open, [1] vehicle_locked
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [1:0] mode, [2] door_line, [3] left_motor,
	                                   // [4] right_motor, [5] door_led_n,
	                                   // [6] left_led_n, [7] right_led_n
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dlwc_pkg::*;

	cfg_t  cfg;
	mode_t mode_next;
	mode_t mode_cur;
	logic  valid_s1;
	logic  door_s1;
	logic  locked_s1;
	logic  space;
	logic  step;

	dlwc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign step          = valid_s1 && space;
	assign s_axis_tready = !valid_s1 || space;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			door_s1   <= s_axis_tdata[0];
			locked_s1 <= s_axis_tdata[1];
		end
	end

	dlwc_fsm u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.door_open      (door_s1),
		.vehicle_locked (locked_s1),
		.cfg            (cfg),
		.mode_next      (mode_next),
		.mode_cur       (mode_cur)
	);

	dlwc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step),
		.mode          (mode_next),
		.space         (space),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// closing never starts straight from unlocked open
	a_no_close_from_open: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_cur == MODE_UNLOCKED_OPEN) |=> (mode_cur != MODE_CLOSING))
		else $error("closing entered from unlocked open");

	// the mode only moves when an item is processed
	a_mode_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_cur))
		else $error("mode changed without an item");

	// a stalled result keeps the held item in the input register
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !space) |=> (valid_s1 && $stable(door_s1) && $stable(locked_s1)))
		else $error("input register lost an item while stalled");

	// result beat mirrors the mode of the state machine
	a_result_mode: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (m_axis_tdata[1:0] == mode_cur))
		else $error("result mode differs from state");

endmodule
